/* rtl/irc_pkg.sv */
// ----------------------------------------------------------------------------
// irc_pkg
// Shared types, widths, register indexes and reset values for the
// irrigation relay controller.
// ----------------------------------------------------------------------------
`default_nettype none

package irc_pkg;

    // field widths
    localparam int RawW     = 12;
    localparam int TimeW    = 32;
    localparam int PctW     = 7;
    localparam int CountW   = 4;
    localparam int EventW   = 2;
    localparam int CfgDataW = 32;
    localparam int CfgIdxW  = 3;

    // scaling: percent = raw * 100 / FullScale
    localparam int ProdW = RawW + PctW;   // raw * 100 fits in 19 bits
    localparam int FullScale = 4095;

    // configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        REG_LOW_THRESHOLD     = 3'd0,
        REG_HIGH_THRESHOLD    = 3'd1,
        REG_MAX_ACTIVATIONS   = 3'd2,
        REG_ACTIVATION_PERIOD = 3'd3,
        REG_MAX_ON_TIME       = 3'd4
    } cfg_index_t;

    // switch event codes
    typedef enum logic [EventW-1:0] {
        EVT_NONE    = 2'd0,
        EVT_ON      = 2'd1,
        EVT_OFF_WET = 2'd2,
        EVT_OFF_TMO = 2'd3
    } switch_event_t;

    // register reset values
    localparam logic [PctW-1:0]   LowThresholdRst     = 7'd30;
    localparam logic [PctW-1:0]   HighThresholdRst    = 7'd60;
    localparam logic [CountW-1:0] MaxActivationsRst   = 4'd3;
    localparam logic [TimeW-1:0]  ActivationPeriodRst = 32'd6000;
    localparam logic [TimeW-1:0]  MaxOnTimeRst        = 32'd1000;

endpackage

`default_nettype wire

/* rtl/irrigation_relay_controller_core.sv */
// ----------------------------------------------------------------------------
// irrigation_relay_controller_core
// Pipeline: an input transfer is captured in the input register and then
// passes to the result register.
// Throughput: one item per cycle; the input stalls only while the result
// register is full and out_ready is low.
// Reset: asynchronous active-low rst_n clears the relay, the activation count,
// the time stamps and all valid bits, and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module irrigation_relay_controller_core (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // configuration write port
    input  wire logic                               cfg_we,
    input  wire logic [irc_pkg::CfgIdxW-1:0]        cfg_index,
    input  wire logic [irc_pkg::CfgDataW-1:0]       cfg_data,
    // input channel
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [irc_pkg::RawW-1:0]           moisture_raw,
    input  wire logic [irc_pkg::TimeW-1:0]          now_ms,
    input  wire logic                               button_pressed,
    // result channel
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic                                    relay_on,
    output logic [irc_pkg::PctW-1:0]                moisture_percent,
    output logic [irc_pkg::CountW-1:0]              activations_used,
    output logic [irc_pkg::EventW-1:0]              switch_event
);

    localparam int RawW   = irc_pkg::RawW;
    localparam int TimeW  = irc_pkg::TimeW;
    localparam int PctW   = irc_pkg::PctW;
    localparam int CountW = irc_pkg::CountW;
    localparam int ProdW  = irc_pkg::ProdW;
    localparam int LoW    = 12;                 // 4096 = FullScale + 1
    localparam int RemW   = LoW + 1;

    // configuration registers
    logic [PctW-1:0]   low_threshold_reg;
    logic [PctW-1:0]   high_threshold_reg;
    logic [CountW-1:0] max_activations_reg;
    logic [TimeW-1:0]  activation_period_reg;
    logic [TimeW-1:0]  max_on_time_reg;

    // controller state
    logic [TimeW-1:0]  period_start_reg, period_start_next;
    logic [CountW-1:0] act_count_reg, act_count_next;
    logic              relay_state_reg, relay_state_next;
    logic [TimeW-1:0]  on_since_reg, on_since_next;

    // stage 1: input register
    logic              s1_valid_reg;
    logic [RawW-1:0]   s1_raw_reg;
    logic [TimeW-1:0]  s1_now_reg;
    logic              s1_button_reg;

    // result register
    logic                  out_valid_reg;
    logic                  relay_on_reg;
    logic [PctW-1:0]       percent_reg;
    logic [CountW-1:0]     act_used_reg;
    irc_pkg::switch_event_t event_reg, event_next;

    logic advance;

    // pipeline moves whenever the result register can take a new item
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_threshold_reg     <= irc_pkg::LowThresholdRst;
            high_threshold_reg    <= irc_pkg::HighThresholdRst;
            max_activations_reg   <= irc_pkg::MaxActivationsRst;
            activation_period_reg <= irc_pkg::ActivationPeriodRst;
            max_on_time_reg       <= irc_pkg::MaxOnTimeRst;
        end
        else if (cfg_we)
        begin
            case (irc_pkg::cfg_index_t'(cfg_index))
                irc_pkg::REG_LOW_THRESHOLD:     low_threshold_reg     <= cfg_data[PctW-1:0];
                irc_pkg::REG_HIGH_THRESHOLD:    high_threshold_reg    <= cfg_data[PctW-1:0];
                irc_pkg::REG_MAX_ACTIVATIONS:   max_activations_reg   <= cfg_data[CountW-1:0];
                irc_pkg::REG_ACTIVATION_PERIOD: activation_period_reg <= cfg_data[TimeW-1:0];
                irc_pkg::REG_MAX_ON_TIME:       max_on_time_reg       <= cfg_data[TimeW-1:0];
                default: ;
            endcase
        end
    end

    // scale to percent: q = x / 4095 with x = hi*4096 + lo,
    // remainder after hi is hi + lo (< 2*4095), so one compare corrects it
    logic [ProdW-1:0] prod;
    logic [PctW-1:0]  prod_hi;
    logic [RemW-1:0]  rem;
    logic [PctW-1:0]  percent;

    always_comb
    begin
        prod    = {1'b0, s1_raw_reg, 6'b0} + {2'b0, s1_raw_reg, 5'b0}
                + {5'b0, s1_raw_reg, 2'b0};
        prod_hi = prod[ProdW-1:LoW];
        rem     = {{(RemW-PctW){1'b0}}, prod_hi} + {1'b0, prod[LoW-1:0]};
        percent = prod_hi + ((rem >= RemW'(irc_pkg::FullScale)) ? 7'd1 : 7'd0);
    end

    // control step on the scaled sample
    logic [TimeW-1:0] period_elapsed;
    logic [TimeW-1:0] on_elapsed;
    logic [CountW-1:0] count_cleared;

    always_comb
    begin
        period_start_next = period_start_reg;
        act_count_next    = act_count_reg;
        relay_state_next  = relay_state_reg;
        on_since_next     = on_since_reg;
        event_next        = irc_pkg::EVT_NONE;
        period_elapsed    = s1_now_reg - period_start_reg;
        count_cleared     = act_count_reg;
        on_elapsed        = '0;

        if (!s1_button_reg)
        begin
            // period rollover
            if (period_elapsed >= activation_period_reg)
            begin
                period_start_next = s1_now_reg;
                count_cleared     = '0;
            end
            act_count_next = count_cleared;

            // dry / wet decision
            if (percent <= low_threshold_reg)
            begin
                if (!relay_state_reg && (count_cleared < max_activations_reg))
                begin
                    relay_state_next = 1'b1;
                    on_since_next    = s1_now_reg;
                    act_count_next   = count_cleared + 4'd1;
                    event_next       = irc_pkg::EVT_ON;
                end
            end
            else if ((percent >= high_threshold_reg) && relay_state_reg)
            begin
                relay_state_next = 1'b0;
                event_next       = irc_pkg::EVT_OFF_WET;
            end

            // on-time limit
            on_elapsed = s1_now_reg - on_since_next;
            if (relay_state_next && (on_elapsed > max_on_time_reg))
            begin
                relay_state_next = 1'b0;
                event_next       = irc_pkg::EVT_OFF_TMO;
            end
        end
    end

    // pipeline control and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            period_start_reg <= '0;
            act_count_reg    <= '0;
            relay_state_reg  <= 1'b0;
            on_since_reg     <= '0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= in_valid;
            out_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                period_start_reg <= period_start_next;
                act_count_reg    <= act_count_next;
                relay_state_reg  <= relay_state_next;
                on_since_reg     <= on_since_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_raw_reg     <= moisture_raw;
            s1_now_reg     <= now_ms;
            s1_button_reg  <= button_pressed;
            relay_on_reg   <= relay_state_next;
            percent_reg    <= percent;
            act_used_reg   <= act_count_next;
            event_reg      <= event_next;
        end
    end

    // outputs
    assign out_valid        = out_valid_reg;
    assign relay_on         = relay_on_reg;
    assign moisture_percent = percent_reg;
    assign activations_used = act_used_reg;
    assign switch_event     = event_reg;

endmodule

`default_nettype wire
